// File: rtl/rhv_pkg.sv
// Package: shared constants, types and codes of the RMSSD window block.
package rhv_pkg;

    localparam int WINDOW     = 32;
    localparam int IBI_W      = 16;
    localparam int SAMPLE_W   = 12;
    localparam int LIMIT_W    = 8;
    localparam int RMSSD_W    = 8;
    localparam int ZONE_W     = 2;
    localparam int RMSSD_MAX  = 255;

    localparam int IDX_W      = $clog2(WINDOW);
    localparam int CNT_W      = $clog2(WINDOW + 1);
    localparam int SQ_W       = 2 * SAMPLE_W;
    localparam int SUM_W      = SQ_W + $clog2(WINDOW);
    localparam int DIVISOR    = WINDOW - 1;
    localparam int ROOT_W     = (SUM_W + 1) / 2;
    localparam int RT2_W      = 2 * ROOT_W;
    localparam int STEP_W     = $clog2(SUM_W + 1);

    // divide by DIVISOR: multiply by ceil(2^DIV_SHIFT / DIVISOR), keep bits above DIV_SHIFT
    localparam int DIV_SHIFT  = SUM_W + $clog2(DIVISOR);
    localparam int MAGIC_W    = SUM_W + 1;
    localparam int PROD_W     = SUM_W + MAGIC_W;
    localparam logic [MAGIC_W-1:0] DIV_MAGIC =
        MAGIC_W'(((64'd1 << DIV_SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR));

    localparam int FIFO_DEPTH = 2;

    localparam int REG_IDX_W  = 2;
    localparam int ADDR_W     = REG_IDX_W + 2;
    localparam int DATA_W     = 32;

    localparam logic [SAMPLE_W-1:0] IBI_MIN_RST        = 12'd300;
    localparam logic [SAMPLE_W-1:0] IBI_MAX_RST        = 12'd2000;
    localparam logic [LIMIT_W-1:0]  LOW_LIMIT_RST      = 8'd5;
    localparam logic [LIMIT_W-1:0]  MODERATE_LIMIT_RST = 8'd15;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_IBI_MIN        = 2'd0,
        REG_IBI_MAX        = 2'd1,
        REG_LOW_LIMIT      = 2'd2,
        REG_MODERATE_LIMIT = 2'd3
    } reg_idx_t;

    typedef enum logic [ZONE_W-1:0] {
        ZONE_LOW      = 2'd0,
        ZONE_MODERATE = 2'd1,
        ZONE_GOOD     = 2'd2
    } zone_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] ibi_min;
        logic [SAMPLE_W-1:0] ibi_max;
        logic [LIMIT_W-1:0]  low_limit;
        logic [LIMIT_W-1:0]  moderate_limit;
    } cfg_t;

    typedef struct packed {
        logic                keep;
        logic [SAMPLE_W-1:0] sample;
    } queue_item_t;

    typedef enum logic [2:0] {
        BK_IDLE = 3'd0,
        BK_WALK = 3'd1,
        BK_DIV  = 3'd2,
        BK_ROOT = 3'd3,
        BK_FIN  = 3'd4,
        BK_DONE = 3'd5
    } back_state_t;

endpackage

// File: rtl/rhv_if.sv
// Interfaces: interval input channel and RMSSD result channel.
interface rhv_in_if;
    import rhv_pkg::*;

    logic             valid;
    logic             ready;
    logic [IBI_W-1:0] interval_ms;

    modport source (output valid, output interval_ms, input ready);
    modport sink (input valid, input interval_ms, output ready);
endinterface

interface rhv_out_if;
    import rhv_pkg::*;

    logic               valid;
    logic               ready;
    logic [RMSSD_W-1:0] rmssd_value;
    logic [ZONE_W-1:0]  hrv_zone;
    logic               reading_valid;

    modport source (output valid, output rmssd_value, output hrv_zone, output reading_valid,
                    input ready);
    modport sink (input valid, input rmssd_value, input hrv_zone, input reading_valid,
                  output ready);
endinterface

// File: rtl/rmssd_hrv_window.sv
// RMSSD heart-rate-variability window: top level with the configuration registers.
//
// ibi carries one inter-beat interval (ms) per transaction; res returns one
// transaction per input: the current RMSSD (saturated at 255), its zone and a
// flag that is set once a full window of samples has produced a reading.
// Intervals outside [ibi_min, ibi_max] leave the state alone and just repeat
// the current values. The APB port holds ibi_min, ibi_max, low_limit and
// moderate_limit at byte addresses 0, 4, 8 and 12; write them while idle.
// A rejected interval, or one taken before the window is full, goes straight
// to the result step. With a full window a kept interval runs a walk over
// the ring RAM, a reciprocal multiply for the divide by WINDOW-1, a
// bit-serial square root and the zone/result steps.
// One item is in the back end at a time; a two-entry queue lets ibi keep
// accepting during a recompute. The result sits in an output register; a
// stalled receiver holds the back end at its final step, and ibi stops only
// once the queue is full. Reset clears the ring pointers, the reading and
// the registers to their defaults; no clearing pass runs, since ring entries
// are read only after being written.
module rmssd_hrv_window (
    input  logic                        clk,
    input  logic                        rst_n,
    rhv_in_if.sink                      ibi,
    rhv_out_if.source                   res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rhv_pkg::ADDR_W-1:0]  paddr,
    input  logic [rhv_pkg::DATA_W-1:0]  pwdata,
    output logic [rhv_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import rhv_pkg::*;

    cfg_t        cfg_reg;
    reg_idx_t    reg_idx;
    logic        cfg_write;
    logic        q_full;
    logic        q_push;
    queue_item_t push_item;
    logic        q_pop;
    logic        q_valid;
    queue_item_t pop_item;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ibi_min        <= IBI_MIN_RST;
            cfg_reg.ibi_max        <= IBI_MAX_RST;
            cfg_reg.low_limit      <= LOW_LIMIT_RST;
            cfg_reg.moderate_limit <= MODERATE_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_IBI_MIN:        cfg_reg.ibi_min        <= pwdata[SAMPLE_W-1:0];
                REG_IBI_MAX:        cfg_reg.ibi_max        <= pwdata[SAMPLE_W-1:0];
                REG_LOW_LIMIT:      cfg_reg.low_limit      <= pwdata[LIMIT_W-1:0];
                REG_MODERATE_LIMIT: cfg_reg.moderate_limit <= pwdata[LIMIT_W-1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_IBI_MIN:        prdata = DATA_W'(cfg_reg.ibi_min);
            REG_IBI_MAX:        prdata = DATA_W'(cfg_reg.ibi_max);
            REG_LOW_LIMIT:      prdata = DATA_W'(cfg_reg.low_limit);
            REG_MODERATE_LIMIT: prdata = DATA_W'(cfg_reg.moderate_limit);
            default:            prdata = '0;
        endcase
    end

    rhv_front u_front (
        .cfg    (cfg_reg),
        .ibi    (ibi),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (push_item)
    );

    rhv_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (pop_item)
    );

    rhv_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (pop_item),
        .q_pop   (q_pop),
        .cfg     (cfg_reg),
        .res     (res)
    );
endmodule

// File: rtl/rhv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rhv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/rhv_fifo.sv
// Short queue between the classifying front end and the compute back end.
module rhv_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rhv_pkg::queue_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 pop_valid,
    output rhv_pkg::queue_item_t pop_item
);
    import rhv_pkg::*;

    localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

    queue_item_t       entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == FCNT_W'(FIFO_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end
endmodule

// File: rtl/rhv_front.sv
// Front end: takes interval transactions and tags each as kept or out of range.
module rhv_front (
    input  rhv_pkg::cfg_t        cfg,
    rhv_in_if.sink               ibi,
    input  logic                 q_full,
    output logic                 q_push,
    output rhv_pkg::queue_item_t q_item
);
    import rhv_pkg::*;

    logic above_min;
    logic below_max;

    assign above_min = (ibi.interval_ms >= IBI_W'(cfg.ibi_min));
    assign below_max = (ibi.interval_ms <= IBI_W'(cfg.ibi_max));

    assign ibi.ready     = !q_full;
    assign q_push        = ibi.valid && !q_full;
    assign q_item.keep   = above_min && below_max;
    // a kept interval never exceeds ibi_max, so the low bits carry it whole
    assign q_item.sample = ibi.interval_ms[SAMPLE_W-1:0];
endmodule

// File: rtl/rhv_back.sv
// Back end: ring update, squared-difference walk, divide, square root, zone, result register.
module rhv_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  rhv_pkg::queue_item_t q_item,
    output logic                 q_pop,
    input  rhv_pkg::cfg_t        cfg,
    rhv_out_if.source            res
);
    import rhv_pkg::*;

    localparam int OPX_W = RT2_W + 1;

    back_state_t         state_reg;
    back_state_t         state_next;

    logic [IDX_W-1:0]    head_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [IDX_W-1:0]    addr_reg;
    logic [CNT_W-1:0]    issue_reg;
    logic                rd_v_reg;
    logic                rd_first_reg;
    logic                sq_v_reg;
    logic [SAMPLE_W-1:0] prev_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [RT2_W-1:0]    res_reg;
    logic [RT2_W-1:0]    one_reg;

    logic [RMSSD_W-1:0]  last_rmssd_reg;
    zone_t               last_zone_reg;
    logic                have_reg;

    logic                out_valid_reg;
    logic [RMSSD_W-1:0]  out_rmssd_reg;
    zone_t               out_zone_reg;
    logic                out_have_reg;

    logic                ram_we;
    logic                issue;
    logic                out_load;
    logic                go_walk;
    logic                walk_done;
    logic [SAMPLE_W-1:0] ram_q;
    logic [IDX_W-1:0]    head_inc;
    logic [IDX_W-1:0]    addr_inc;
    logic [SAMPLE_W-1:0] diff;
    logic [PROD_W-1:0]   div_prod;
    logic [OPX_W-1:0]    rt_op;
    logic [OPX_W-1:0]    rt_trial;
    logic                rt_ge;
    logic [RMSSD_W-1:0]  rmssd_sat;
    zone_t               zone_new;

    rhv_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head_reg),
        .wdata (q_item.sample),
        .raddr (addr_reg),
        .rdata (ram_q)
    );

    assign head_inc  = (head_reg == IDX_W'(WINDOW - 1)) ? '0 : head_reg + 1'b1;
    assign addr_inc  = (addr_reg == IDX_W'(WINDOW - 1)) ? '0 : addr_reg + 1'b1;
    assign go_walk   = q_item.keep && (fill_reg >= CNT_W'(WINDOW - 1));
    assign walk_done = (issue_reg == CNT_W'(WINDOW)) && !rd_v_reg && !sq_v_reg;

    assign diff      = (ram_q >= prev_reg) ? ram_q - prev_reg : prev_reg - ram_q;

    // divide by the fixed WINDOW-1 as a multiply by its rounded-up reciprocal
    assign div_prod  = PROD_W'(sum_reg) * PROD_W'(DIV_MAGIC);

    // digit-by-digit square root, one root bit per cycle
    assign rt_op     = OPX_W'(sum_reg);
    assign rt_trial  = OPX_W'(res_reg) + OPX_W'(one_reg);
    assign rt_ge     = (rt_op >= rt_trial);

    assign rmssd_sat = (res_reg > RT2_W'(RMSSD_MAX)) ? RMSSD_W'(RMSSD_MAX)
                                                     : res_reg[RMSSD_W-1:0];

    always_comb
    begin
        if (rmssd_sat < cfg.low_limit)
        begin
            zone_new = ZONE_LOW;
        end
        else if (rmssd_sat <= cfg.moderate_limit)
        begin
            zone_new = ZONE_MODERATE;
        end
        else
        begin
            zone_new = ZONE_GOOD;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = go_walk ? BK_WALK : BK_DONE;
                end
            end
            BK_WALK:
            begin
                if (walk_done)
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                state_next = BK_ROOT;
            end
            BK_ROOT:
            begin
                if (step_reg == STEP_W'(ROOT_W - 1))
                begin
                    state_next = BK_FIN;
                end
            end
            BK_FIN:
            begin
                state_next = BK_DONE;
            end
            BK_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        q_pop    = 1'b0;
        ram_we   = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                q_pop  = q_valid;
                ram_we = q_valid && q_item.keep;
            end
            BK_WALK:
            begin
                issue = (issue_reg != CNT_W'(WINDOW));
            end
            BK_DONE:
            begin
                out_load = !out_valid_reg || res.ready;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            head_reg       <= '0;
            fill_reg       <= '0;
            issue_reg      <= '0;
            rd_v_reg       <= 1'b0;
            sq_v_reg       <= 1'b0;
            step_reg       <= '0;
            last_rmssd_reg <= '0;
            last_zone_reg  <= ZONE_LOW;
            have_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= issue;
            sq_v_reg  <= rd_v_reg && !rd_first_reg;
            step_reg  <= (state_next != state_reg) ? '0 : step_reg + 1'b1;
            if (ram_we)
            begin
                head_reg <= head_inc;
                if (fill_reg != CNT_W'(WINDOW))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (q_pop)
            begin
                issue_reg <= '0;
            end
            else if (issue)
            begin
                issue_reg <= issue_reg + 1'b1;
            end
            if (state_reg == BK_FIN)
            begin
                last_rmssd_reg <= rmssd_sat;
                last_zone_reg  <= zone_new;
                have_reg       <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            addr_reg     <= addr_inc;
            rd_first_reg <= (issue_reg == '0);
        end
        if (rd_v_reg)
        begin
            prev_reg <= ram_q;
            sq_reg   <= SQ_W'(diff) * SQ_W'(diff);
        end
        if (out_load)
        begin
            out_rmssd_reg <= last_rmssd_reg;
            out_zone_reg  <= last_zone_reg;
            out_have_reg  <= have_reg;
        end
        case (state_reg)
            BK_IDLE:
            begin
                // oldest sample sits at the slot after the one just written
                addr_reg <= head_inc;
                sum_reg  <= '0;
            end
            BK_WALK:
            begin
                if (sq_v_reg)
                begin
                    sum_reg <= sum_reg + SUM_W'(sq_reg);
                end
                res_reg <= '0;
                one_reg <= RT2_W'(1) << (RT2_W - 2);
            end
            BK_DIV:
            begin
                sum_reg <= SUM_W'(div_prod[PROD_W-1:DIV_SHIFT]);
            end
            BK_ROOT:
            begin
                if (rt_ge)
                begin
                    sum_reg <= SUM_W'(rt_op - rt_trial);
                    res_reg <= (res_reg >> 1) + one_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                one_reg <= one_reg >> 2;
            end
            default:
            begin
                one_reg <= one_reg;
            end
        endcase
    end

    assign res.valid         = out_valid_reg;
    assign res.rmssd_value   = out_rmssd_reg;
    assign res.hrv_zone      = out_zone_reg;
    assign res.reading_valid = out_have_reg;
endmodule

// File: rtl/rhv_checker.sv
// Port-level assertions for the RMSSD window block, bound to the top level.
module rhv_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [rhv_pkg::RMSSD_W-1:0] rmssd_value,
    input logic [rhv_pkg::ZONE_W-1:0]  hrv_zone,
    input logic                        reading_valid
);
    import rhv_pkg::*;

    logic [3:0] pending_reg;
    logic       seen_reg;
    logic       in_xact;
    logic       out_xact;

    assign in_xact  = in_valid && in_ready;
    assign out_xact = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            seen_reg    <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_reg + {3'd0, in_xact} - {3'd0, out_xact};
            if (out_xact && reading_valid)
            begin
                seen_reg <= 1'b1;
            end
        end
    end

    // a result never shows up ahead of the transaction that causes it
    a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != 4'd0))
        else $error("result offered with no input transaction outstanding");

    // before the first full window the result carries the reset values
    a_no_reading_defaults: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reading_valid |-> (rmssd_value == '0) && (hrv_zone == ZONE_LOW))
        else $error("rmssd or zone nonzero without a reading");

    // once a reading exists it stays
    a_reading_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_reg |-> reading_valid)
        else $error("reading_valid dropped after a reading");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rmssd_value)
                                    && $stable(hrv_zone) && $stable(reading_valid))
        else $error("stalled result changed");
endmodule

bind rmssd_hrv_window rhv_checker u_rhv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (ibi.valid),
    .in_ready      (ibi.ready),
    .out_valid     (res.valid),
    .out_ready     (res.ready),
    .rmssd_value   (res.rmssd_value),
    .hrv_zone      (res.hrv_zone),
    .reading_valid (res.reading_valid)
);

// File: tb/rmssd_checker.sv
`timescale 1ns / 100ps
// Checker: snoops the interval, result and APB traffic, predicts each result and compares.
module rmssd_checker
    import rhv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    rhv_in_if                 ibi,
    rhv_out_if                res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    output int                outstanding,
    output int                errors
);

    typedef struct packed {
        logic [RMSSD_W-1:0] rmssd;
        zone_t              zone;
        logic               valid;
    } reading_t;

    reading_t            expected_readings[$];
    reading_t            current;
    reading_t            want;
    logic [SAMPLE_W-1:0] ring [WINDOW];
    int                  head;
    int                  fill;
    cfg_t                cfg;
    int                  result_no;

    initial errors = 0;

    function automatic logic [RMSSD_W-1:0] sat_isqrt(input longint unsigned n);
        longint unsigned x;
        longint unsigned y;
        if (n == 0)
            return '0;
        x = n;
        y = (x + 1) >> 1;
        while (y < x)
        begin
            x = y;
            y = (x + n / x) >> 1;
        end
        return (x > RMSSD_MAX) ? RMSSD_W'(RMSSD_MAX) : RMSSD_W'(x);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (errors < 40)
            $display("%0t: mismatch on result %0d, %s: got %0d expected %0d",
                     $realtime, result_no, what, got, exp_val);
        errors++;
    endtask

    // Accepted samples update the ring; a full ring recomputes over oldest..newest.
    task automatic take_interval(input logic [IBI_W-1:0] v);
        longint unsigned sq_sum;
        int              i;
        int              a;
        int              b;
        int              d;
        if (v >= cfg.ibi_min && v <= cfg.ibi_max)
        begin
            ring[head] = v[SAMPLE_W-1:0];
            head = (head + 1) % WINDOW;
            if (fill < WINDOW)
                fill++;
            if (fill >= WINDOW)
            begin
                sq_sum = 0;
                for (i = 0; i < WINDOW - 1; i++)
                begin
                    a = ring[(head + i) % WINDOW];
                    b = ring[(head + i + 1) % WINDOW];
                    d = (b >= a) ? b - a : a - b;
                    sq_sum += longint'(d) * longint'(d);
                end
                current.rmssd = sat_isqrt(sq_sum / (WINDOW - 1));
                current.valid = 1'b1;
                if (current.rmssd < cfg.low_limit)
                    current.zone = ZONE_LOW;
                else if (current.rmssd <= cfg.moderate_limit)
                    current.zone = ZONE_MODERATE;
                else
                    current.zone = ZONE_GOOD;
            end
        end
        expected_readings.push_back(current);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            expected_readings.delete();
            current     = '{rmssd: '0, zone: ZONE_LOW, valid: 1'b0};
            head        = 0;
            fill        = 0;
            result_no   = 0;
            cfg         = '{ibi_min: IBI_MIN_RST, ibi_max: IBI_MAX_RST,
                            low_limit: LOW_LIMIT_RST, moderate_limit: MODERATE_LIMIT_RST};
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_IBI_MIN:        cfg.ibi_min        = pwdata[SAMPLE_W-1:0];
                    REG_IBI_MAX:        cfg.ibi_max        = pwdata[SAMPLE_W-1:0];
                    REG_LOW_LIMIT:      cfg.low_limit      = pwdata[LIMIT_W-1:0];
                    REG_MODERATE_LIMIT: cfg.moderate_limit = pwdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end

            // results leave before the input of this edge can have produced one
            if (res.valid && res.ready)
            begin
                if (expected_readings.size() == 0)
                    report_mismatch("transaction with none pending, rmssd_value",
                                    res.rmssd_value, -1);
                else
                begin
                    want = expected_readings.pop_front();
                    if (res.rmssd_value !== want.rmssd)
                        report_mismatch("rmssd_value", res.rmssd_value, want.rmssd);
                    if (res.hrv_zone !== want.zone)
                        report_mismatch("hrv_zone", res.hrv_zone, want.zone);
                    if (res.reading_valid !== want.valid)
                        report_mismatch("reading_valid", res.reading_valid, want.valid);
                end
                result_no++;
            end

            if (ibi.valid && ibi.ready)
                take_interval(ibi.interval_ms);

            outstanding <= expected_readings.size();
        end
    end

endmodule

// File: tb/tb_rmssd_hrv_window.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, APB setup, interval stimulus with idling, and the verdict.
module tb_rmssd_hrv_window;
    import rhv_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 115;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int outstanding;
    int errors;
    int cycles = 0;
    int ready_hold = 0;
    bit idle_on = 1'b1;
    int walk_pos;

    rhv_in_if  ibi_ch ();
    rhv_out_if res_ch ();

    always #2 clk = ~clk;

    rmssd_hrv_window u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .ibi     (ibi_ch.sink),
        .res     (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rmssd_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .ibi         (ibi_ch),
        .res         (res_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .outstanding (outstanding),
        .errors      (errors)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side back-pressure in random bursts
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold   <= ready_hold - 1;
            res_ch.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            ready_hold   <= $urandom_range(0, 5);
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= 1'b1;
    end

    task automatic send_interval(input logic [IBI_W-1:0] v);
        ibi_ch.valid       <= 1'b1;
        ibi_ch.interval_ms <= v;
        @(posedge clk);
        while (!ibi_ch.ready)
            @(posedge clk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // every transaction yields a result, so an empty store means the block is idle
    task automatic drain;
        ibi_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_config(input int lo, input int hi, input int low_lim, input int mod_lim);
        drain();
        apb_write(REG_IBI_MIN, lo);
        apb_write(REG_IBI_MAX, hi);
        apb_write(REG_LOW_LIMIT, low_lim);
        apb_write(REG_MODERATE_LIMIT, mod_lim);
    endtask

    // Mostly a random walk inside the accepted range; jitter < 0 flips between the bounds.
    function automatic logic [IBI_W-1:0] next_interval(input int lo, input int hi,
                                                       input int jitter);
        int r;
        r = $urandom_range(0, 99);
        if (lo > hi || r < 10)
            return IBI_W'($urandom_range(0, 65535));
        if (r < 16)
        begin
            case ($urandom_range(0, 3))
                0:       return IBI_W'(lo - 1);
                1:       return IBI_W'(hi + 1);
                2:       return IBI_W'(lo);
                default: return IBI_W'(hi);
            endcase
        end
        if (jitter < 0)
            walk_pos = (walk_pos == lo) ? hi : lo;
        else
            walk_pos = walk_pos + $urandom_range(0, 2 * jitter) - jitter;
        if (walk_pos < lo)
            walk_pos = lo;
        if (walk_pos > hi)
            walk_pos = hi;
        return IBI_W'(walk_pos);
    endfunction

    initial
    begin
        int k;
        int i;
        int lo;
        int hi;
        int low_lim;
        int mod_lim;
        int jit;

        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        ibi_ch.valid       = 1'b0;
        ibi_ch.interval_ms = '0;
        res_ch.ready       = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limits: edges of the accepted range, high bits, no reading yet
        send_interval(16'd0);
        send_interval(16'hFFFF);
        send_interval(16'd4096);
        send_interval(16'd299);
        send_interval(16'd300);
        send_interval(16'd2000);
        send_interval(16'd2001);
        send_interval(16'hAAAA);
        send_interval(16'h5555);
        send_interval(16'd1000);
        send_interval(16'd1005);

        // minimum above maximum rejects everything
        set_config(3000, 100, LOW_LIMIT_RST, MODERATE_LIMIT_RST);
        send_interval(16'd0);
        send_interval(16'd100);
        send_interval(16'd1500);
        send_interval(16'd3000);
        send_interval(16'd4095);

        // full 12-bit range
        set_config(0, 4095, 0, 255);
        send_interval(16'd0);
        send_interval(16'd4095);
        send_interval(16'd4096);

        for (k = 0; k < PHASES; k++)
        begin
            case (k)
                0:
                begin
                    lo = 0; hi = 4095; low_lim = 0; mod_lim = 255; jit = -1;
                end
                1:
                begin
                    // limits in reverse order
                    lo = 0; hi = 4095; low_lim = 255; mod_lim = 0; jit = 300;
                end
                2:
                begin
                    lo = 300; hi = 2000; low_lim = 5; mod_lim = 15; jit = 6;
                end
                PHASES - 1:
                begin
                    lo = 300; hi = 2000; low_lim = 5; mod_lim = 15; jit = 15;
                end
                default:
                begin
                    lo      = $urandom_range(0, 900);
                    hi      = $urandom_range(1200, 4095);
                    low_lim = $urandom_range(0, 40);
                    mod_lim = $urandom_range(0, 60);
                    case ($urandom_range(0, 6))
                        0:       jit = 0;
                        1:       jit = 2;
                        2:       jit = 6;
                        3:       jit = 15;
                        4:       jit = 40;
                        5:       jit = 300;
                        default: jit = 4095;
                    endcase
                end
            endcase
            idle_on = !(k == 2 || k == PHASES - 1);
            set_config(lo, hi, low_lim, mod_lim);
            walk_pos = (lo + hi) / 2;
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (idle_on && $urandom_range(0, 4) == 0)
                begin
                    ibi_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
                send_interval(next_interval(lo, hi, jit));
            end
        end

        drain();
        repeat (100) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
